[rtl/status_led_pattern_sequencer_top_defines.svh]
// Assertion macros for the status LED pattern sequencer checker.
// Depends on signals named clock and reset in the scope of use.
`ifndef STATUS_LED_PATTERN_SEQUENCER_TOP_DEFINES_SVH
`define STATUS_LED_PATTERN_SEQUENCER_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define SLPS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SLPS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/slps_pkg.sv]
// Types, codes and constants of the status LED pattern sequencer.
// Used by every module of the block; depends on nothing.
package slps_pkg;

   typedef enum logic [1:0] {
      PHASE_STATUS = 2'd0,
      PHASE_ID     = 2'd1,
      PHASE_LINK   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_NO_TIME    = 2'd0,
      ST_CLOCK_ONLY = 2'd1,
      ST_NETWORK    = 2'd2,
      ST_OSC_BAD    = 2'd3
   } status_type;

   localparam logic [1:0] MODE_STATUS = 2'd0;
   localparam logic [1:0] MODE_ID     = 2'd1;
   localparam logic [1:0] MODE_LINK   = 2'd2;

   localparam logic [1:0] SRC_CLOCK_ONLY = 2'd1;
   localparam logic [1:0] SRC_NETWORK    = 2'd2;

   localparam logic CSR_DEVICE_MAC = 1'b0;
   localparam logic CSR_LED_ENABLE = 1'b1;

   localparam int MAC_WIDTH = 48;
   localparam int MAC_NIBBLES = MAC_WIDTH / 4;

   localparam logic [7:0] LEVEL_RED   = 8'd40;
   localparam logic [7:0] LEVEL_GREEN = 8'd40;
   localparam logic [7:0] LEVEL_AMBER = 8'd20;
   localparam logic [7:0] LEVEL_BLUE  = 8'd60;

   localparam logic [4:0] ID_ON_TICKS     = 5'd3;
   localparam logic [4:0] ID_FLASH_LAST   = 5'd6;
   localparam logic [4:0] ID_PAUSE_LAST   = 5'd19;
   localparam logic [4:0] ZERO_ON_TICKS   = 5'd10;
   localparam logic [4:0] ZERO_LAST       = 5'd19;
   localparam logic [4:0] LINK_LAST       = 5'd11;

   typedef struct packed {
      logic [7:0] red_level;
      logic [7:0] green_level;
      logic [7:0] blue_level;
      logic [1:0] show_mode;
   } rsp_payload_type;

   // Lowest nibble of the MAC below ten, or zero when there is none.
   function automatic logic [3:0] id_count(input logic [MAC_WIDTH-1:0] mac);
      logic [3:0] n;
      logic [3:0] nib;
      n = 4'd0;
      for (int i = MAC_NIBBLES - 1; i >= 0; i--) begin
         nib = mac[4*i +: 4];
         if (nib < 4'd10) begin
            n = nib;
         end
      end
      return n;
   endfunction

   function automatic logic mod6_zero(input logic [4:0] s);
      logic z;
      case (s)
         5'd0, 5'd6, 5'd12, 5'd18, 5'd24, 5'd30: z = 1'b1;
         default: z = 1'b0;
      endcase
      return z;
   endfunction

endpackage

[rtl/slps_req_if.sv]
// Request channel of the status LED pattern sequencer: valid, ready and one tick.
// Standalone; no package needed.
interface slps_req_if;
   logic       valid;
   logic       ready;
   logic       osc_stopped;
   logic [1:0] time_source;
   logic       link_up;

   modport source (output valid, osc_stopped, time_source, link_up, input ready);
   modport sink (input valid, osc_stopped, time_source, link_up, output ready);
endinterface

[rtl/slps_rsp_if.sv]
// Result channel of the status LED pattern sequencer: valid, ready and one colour.
// Standalone; no package needed.
interface slps_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_level;
   logic [7:0] green_level;
   logic [7:0] blue_level;
   logic [1:0] show_mode;

   modport source (output valid, red_level, green_level, blue_level, show_mode,
                   input ready);
   modport sink (input valid, red_level, green_level, blue_level, show_mode,
                 output ready);
endinterface

[rtl/status_led_pattern_sequencer_top.sv]
// Status LED pattern sequencer: one request per 50 ms tick, one colour per request.
// The result of an accepted request is registered in the output buffer; one request
// is taken every cycle while the skid register of the output buffer is empty.
// A two-entry output buffer keeps requests flowing while a result waits.
// Synchronous reset puts the sequencer at the start of the identifier burst and
// clears the configuration registers to zero.
module status_led_pattern_sequencer_top
   import slps_pkg::*;
#(
   parameter int STEP_TICKS      = 10,
   parameter int ID_PERIOD_STEPS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   slps_req_if.sink             req_if,
   slps_rsp_if.source           rsp_if,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [MAC_WIDTH-1:0] csr_wdata
);

   logic            led_enable;
   logic [3:0]      id_count_val;
   logic            accept;
   rsp_payload_type core_result;
   rsp_payload_type out_data;

   assign accept = req_if.valid && req_if.ready;

   slps_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .id_count_out (id_count_val),
      .led_enable   (led_enable)
   );

   slps_core #(
      .STEP_TICKS      (STEP_TICKS),
      .ID_PERIOD_STEPS (ID_PERIOD_STEPS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .led_enable  (led_enable),
      .id_count_in (id_count_val),
      .accept      (accept),
      .osc_stopped (req_if.osc_stopped),
      .time_source (req_if.time_source),
      .link_up     (req_if.link_up),
      .result      (core_result)
   );

   slps_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_data   (core_result),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (out_data)
   );

   assign rsp_if.red_level   = out_data.red_level;
   assign rsp_if.green_level = out_data.green_level;
   assign rsp_if.blue_level  = out_data.blue_level;
   assign rsp_if.show_mode   = out_data.show_mode;

endmodule

[rtl/slps_csr.sv]
// Configuration registers: keeps the identifier flash count and the enable.
// Depends on slps_pkg.
module slps_csr
   import slps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [MAC_WIDTH-1:0] csr_wdata,
   output logic [3:0]           id_count_out,
   output logic                 led_enable
);

   logic [3:0] id_count_ff;
   logic [3:0] id_count_in;
   logic       enable_ff;
   logic       enable_in;

   always_comb begin
      id_count_in = id_count_ff;
      enable_in   = enable_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEVICE_MAC: id_count_in = id_count(csr_wdata);
            CSR_LED_ENABLE: enable_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_count_ff <= 4'd0;
         enable_ff   <= 1'b0;
      end else begin
         id_count_ff <= id_count_in;
         enable_ff   <= enable_in;
      end
   end

   assign id_count_out = id_count_ff;
   assign led_enable   = enable_ff;

endmodule

[rtl/slps_core.sv]
// Sequencer state and the per-tick colour decision for one request.
// Depends on slps_pkg.
module slps_core
   import slps_pkg::*;
#(
   parameter int STEP_TICKS      = 10,
   parameter int ID_PERIOD_STEPS = 24
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            led_enable,
   input  logic [3:0]      id_count_in,
   input  logic            accept,
   input  logic            osc_stopped,
   input  logic [1:0]      time_source,
   input  logic            link_up,
   output rsp_payload_type result
);

   localparam logic [4:0] STEP_LAST   = 5'(STEP_TICKS - 1);
   localparam logic [4:0] PERIOD_LAST = 5'(ID_PERIOD_STEPS);

   phase_type  phase_ff, phase_in;
   logic [4:0] ticks_ff, ticks_in;
   logic [3:0] flash_ff, flash_in;
   logic [4:0] step_ff, step_in;
   logic       link_was_ff, link_was_in;
   status_type held_ff, held_in;

   logic       tick_zero;
   logic       link_edge;
   status_type sampled;
   status_type held_sel;
   logic [4:0] step_inc;

   assign tick_zero = (ticks_ff == 5'd0);
   assign link_edge = tick_zero && link_up && !link_was_ff;
   assign step_inc  = step_ff + 5'd1;
   assign held_sel  = tick_zero ? sampled : held_ff;

   always_comb begin
      if (osc_stopped) begin
         sampled = ST_OSC_BAD;
      end else if (time_source == SRC_NETWORK) begin
         sampled = ST_NETWORK;
      end else if (time_source == SRC_CLOCK_ONLY) begin
         sampled = ST_CLOCK_ONLY;
      end else begin
         sampled = ST_NO_TIME;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      ticks_in    = ticks_ff;
      flash_in    = flash_ff;
      step_in     = step_ff;
      link_was_in = link_was_ff;
      held_in     = held_ff;
      if (!led_enable) begin
         phase_in    = PHASE_ID;
         ticks_in    = 5'd0;
         flash_in    = 4'd0;
         step_in     = 5'd0;
         link_was_in = 1'b0;
         held_in     = ST_NO_TIME;
      end else begin
         unique case (phase_ff)
            PHASE_ID: begin
               if (id_count_in == 4'd0) begin
                  if (ticks_ff >= ZERO_LAST) begin
                     phase_in = PHASE_STATUS;
                     ticks_in = 5'd0;
                     flash_in = 4'd0;
                  end else begin
                     ticks_in = ticks_ff + 5'd1;
                  end
               end else if (flash_ff < id_count_in) begin
                  if (ticks_ff >= ID_FLASH_LAST) begin
                     flash_in = flash_ff + 4'd1;
                     ticks_in = 5'd0;
                  end else begin
                     ticks_in = ticks_ff + 5'd1;
                  end
               end else begin
                  if (ticks_ff >= ID_PAUSE_LAST) begin
                     phase_in = PHASE_STATUS;
                     ticks_in = 5'd0;
                     flash_in = 4'd0;
                  end else begin
                     ticks_in = ticks_ff + 5'd1;
                  end
               end
            end
            PHASE_LINK: begin
               if (ticks_ff >= LINK_LAST) begin
                  phase_in = PHASE_STATUS;
                  ticks_in = 5'd0;
               end else begin
                  ticks_in = ticks_ff + 5'd1;
               end
            end
            default: begin
               phase_in = PHASE_STATUS;
               if (tick_zero) begin
                  held_in = sampled;
                  link_was_in = link_up;
               end
               if (link_edge) begin
                  step_in  = 5'd0;
                  phase_in = PHASE_LINK;
                  ticks_in = 5'd1;
               end else if (ticks_ff >= STEP_LAST) begin
                  ticks_in = 5'd0;
                  if (step_inc >= PERIOD_LAST) begin
                     step_in  = 5'd0;
                     phase_in = PHASE_ID;
                     flash_in = 4'd0;
                  end else begin
                     step_in = step_inc;
                  end
               end else begin
                  ticks_in = ticks_ff + 5'd1;
               end
            end
         endcase
      end
   end

   always_comb begin
      result = '0;
      if (led_enable) begin
         unique case (phase_ff)
            PHASE_ID: begin
               result.show_mode = MODE_ID;
               if (id_count_in == 4'd0) begin
                  if (ticks_ff < ZERO_ON_TICKS) begin
                     result.blue_level = LEVEL_BLUE;
                  end
               end else if (flash_ff < id_count_in && ticks_ff < ID_ON_TICKS) begin
                  result.blue_level = LEVEL_BLUE;
               end
            end
            PHASE_LINK: begin
               result.show_mode = MODE_LINK;
               if (!ticks_ff[1]) begin
                  result.blue_level = LEVEL_BLUE;
               end
            end
            default: begin
               if (link_edge) begin
                  result.show_mode  = MODE_LINK;
                  result.blue_level = LEVEL_BLUE;
               end else begin
                  result.show_mode = MODE_STATUS;
                  case (held_sel)
                     ST_OSC_BAD: begin
                        if (step_ff[0]) begin
                           result.red_level = LEVEL_RED;
                        end
                     end
                     ST_NETWORK: begin
                        if (mod6_zero(step_ff)) begin
                           result.green_level = LEVEL_GREEN;
                        end
                     end
                     ST_CLOCK_ONLY: begin
                        if (step_ff[1:0] != 2'd3) begin
                           result.red_level   = LEVEL_RED;
                           result.green_level = LEVEL_AMBER;
                        end
                     end
                     default: result.red_level = LEVEL_RED;
                  endcase
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_ID;
         ticks_ff    <= 5'd0;
         flash_ff    <= 4'd0;
         step_ff     <= 5'd0;
         link_was_ff <= 1'b0;
         held_ff     <= ST_NO_TIME;
      end else if (accept) begin
         phase_ff    <= phase_in;
         ticks_ff    <= ticks_in;
         flash_ff    <= flash_in;
         step_ff     <= step_in;
         link_was_ff <= link_was_in;
         held_ff     <= held_in;
      end
   end

endmodule

[rtl/slps_out_buf.sv]
// Two-entry result buffer: an output register with a skid register behind it.
// Depends on slps_pkg.
module slps_out_buf
   import slps_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  rsp_payload_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_payload_type out_data
);

   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type main_ff, main_in;
   rsp_payload_type skid_ff, skid_in;
   logic            push;

   assign in_ready = !skid_valid_ff;
   assign push     = in_valid && in_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

[rtl/slps_checker.sv]
// Port-level checks of the status LED pattern sequencer, bound to its top level.
// Depends on slps_pkg and the assertion macro header.
`include "status_led_pattern_sequencer_top_defines.svh"

module slps_checker
   import slps_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] red_level,
   input logic [7:0] green_level,
   input logic [7:0] blue_level,
   input logic [1:0] show_mode
);

   `SLPS_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid right after reset")
   `SLPS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "stalled result dropped")
   `SLPS_ASSERT(a_mode_code, rsp_valid |-> show_mode != 2'd3, "unused show mode code")
   `SLPS_ASSERT(a_blue_only, rsp_valid && show_mode != MODE_STATUS |-> red_level == 8'd0 && green_level == 8'd0, "flash shows a colour other than blue")
   `SLPS_ASSERT(a_status_colour, rsp_valid && show_mode == MODE_STATUS |-> blue_level == 8'd0, "status pattern shows blue")

endmodule

bind status_led_pattern_sequencer_top slps_checker u_slps_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .red_level   (rsp_if.red_level),
   .green_level (rsp_if.green_level),
   .blue_level  (rsp_if.blue_level),
   .show_mode   (rsp_if.show_mode)
);
